// File: hw/rtl/sls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sls_pkg
// Shared types and constants for the sprite line search block.
// ----------------------------------------------------------------------------
package sls_pkg;

  localparam int OBJECT_COUNT_DEF = 40;
  localparam int MAX_PER_LINE_DEF = 10;

  localparam logic [7:0] Y_LIMIT      = 8'd160;
  localparam logic [7:0] Y_OFFSET     = 8'd16;
  localparam logic [7:0] HEIGHT_SHORT = 8'd8;
  localparam logic [7:0] HEIGHT_TALL  = 8'd16;
  localparam logic [7:0] READ_MISS    = 8'hFF;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_SCAN  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN_RD,
    ST_SCAN_EVAL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [7:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// File: hw/rtl/sls_attr_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sls_attr_mem
// Attribute byte memory, one write and one registered read port. Per-byte
// valid bits make never-written bytes read as zero after reset.
// ----------------------------------------------------------------------------
module sls_attr_mem
  import sls_pkg::*;
#(
  parameter int MEM_BYTES = 4 * OBJECT_COUNT_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mem_req_t req,
  output logic [7:0]    rdata
);

  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

  logic [7:0]           mem [MEM_BYTES];
  logic [MEM_BYTES-1:0] valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= valid[req.raddr[AW-1:0]] ? mem[req.raddr[AW-1:0]] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.waddr[AW-1:0]] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sls_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sls_ctrl
// Sequencer for byte access and line scan, with the result register.
// ----------------------------------------------------------------------------
module sls_ctrl
  import sls_pkg::*;
#(
  parameter int OBJECT_COUNT = OBJECT_COUNT_DEF,
  parameter int MAX_PER_LINE = MAX_PER_LINE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       tall,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] byte_address,
  input  wire logic [7:0] write_byte,
  input  wire logic [7:0] line_number,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      read_byte,
  output logic [5:0]      object_index,
  output logic            object_found,
  output logic            last,
  output mem_req_t        mem_req,
  input  wire logic [7:0] mem_rdata
);

  localparam int         MEM_BYTES = 4 * OBJECT_COUNT;
  localparam logic [8:0] MEM_LIMIT = 9'(MEM_BYTES);
  localparam int         IDX_W     = (OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1;
  localparam int         HIT_W     = $clog2(MAX_PER_LINE + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(OBJECT_COUNT - 1);
  localparam logic [HIT_W-1:0] HIT_LAST = HIT_W'(MAX_PER_LINE - 1);

  state_t state, state_next;

  logic             accept;
  logic             in_range;
  logic             slot_free;
  logic             out_load;
  logic             eval_go;
  logic             hit;
  logic [7:0]       lower;
  logic [7:0]       upper;
  logic [7:0]       height;
  logic [7:0]       read_byte_next;
  logic [5:0]       object_index_next;
  logic             object_found_next;
  logic             last_next;

  logic             oob;
  logic [7:0]       line;
  logic [IDX_W-1:0] idx;
  logic [HIT_W-1:0] hits;
  logic             pending;
  logic [IDX_W-1:0] pend_idx;

  assign accept    = in_valid && in_ready;
  assign in_range  = {1'b0, byte_address} < MEM_LIMIT;
  assign slot_free = !out_valid || out_ready;

  assign height = tall ? HEIGHT_TALL : HEIGHT_SHORT;
  assign lower  = mem_rdata - Y_OFFSET;
  assign upper  = lower + height;
  assign hit    = (mem_rdata != 8'd0) && (mem_rdata < Y_LIMIT)
                  && (line >= lower) && (line < upper);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode_t'(mode))
            MODE_READ: state_next = ST_READ;
            MODE_SCAN: state_next = ST_SCAN_RD;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        if (slot_free) state_next = ST_IDLE;
      end
      ST_SCAN_RD: state_next = ST_SCAN_EVAL;
      ST_SCAN_EVAL: begin
        if (eval_go) begin
          if ((hit && hits == HIT_LAST) || idx == IDX_LAST) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SCAN_RD;
          end
        end
      end
      ST_FINISH: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready          = 1'b0;
    mem_req           = '0;
    out_load          = 1'b0;
    eval_go           = 1'b0;
    read_byte_next    = 8'd0;
    object_index_next = 6'd0;
    object_found_next = 1'b0;
    last_next         = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && in_range) begin
          case (mode_t'(mode))
            MODE_WRITE: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = byte_address;
              mem_req.wdata = write_byte;
            end
            MODE_READ: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = byte_address;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        out_load       = slot_free;
        read_byte_next = oob ? READ_MISS : mem_rdata;
        last_next      = 1'b1;
      end
      ST_SCAN_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = 8'({idx, 2'b00});
      end
      ST_SCAN_EVAL: begin
        // an earlier hit goes out once a newer one proves it is not the last
        eval_go           = !(hit && pending && !slot_free);
        out_load          = hit && pending && slot_free;
        object_index_next = 6'(pend_idx);
        object_found_next = 1'b1;
      end
      ST_FINISH: begin
        out_load          = slot_free;
        object_index_next = pending ? 6'(pend_idx) : 6'd0;
        object_found_next = pending;
        last_next         = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_load || (out_valid && !out_ready);
      if (state == ST_IDLE && accept) begin
        pending <= 1'b0;
      end else if (state == ST_SCAN_EVAL && eval_go && hit) begin
        pending <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      oob  <= !in_range;
      line <= line_number;
      idx  <= '0;
      hits <= '0;
    end else if (state == ST_SCAN_EVAL && eval_go) begin
      idx <= idx + 1'b1;
      if (hit) begin
        hits     <= hits + 1'b1;
        pend_idx <= idx;
      end
    end
    if (out_load) begin
      read_byte    <= read_byte_next;
      object_index <= object_index_next;
      object_found <= object_found_next;
      last         <= last_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sprite_line_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_line_search
// Object attribute memory with byte access and a per-line visible object scan.
// Write: no result. Read: the memory read is registered, then the byte goes to
// the result register once the output is free. Scan: each entry is a memory
//   read state, then a compare state; output stalls hold the scan back.
// One item at a time; the result register frees the input side meanwhile.
// Reset clears the config bit and all memory valid bits.
// ----------------------------------------------------------------------------
module sprite_line_search
  import sls_pkg::*;
#(
  parameter int OBJECT_COUNT = OBJECT_COUNT_DEF,
  parameter int MAX_PER_LINE = MAX_PER_LINE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] byte_address,
  input  wire logic [7:0] write_byte,
  input  wire logic [7:0] line_number,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      read_byte,
  output logic [5:0]      object_index,
  output logic            object_found,
  output logic            last
);

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;
  logic       tall_objects;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tall_objects <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      tall_objects <= cfg_data;
    end
  end

  sls_attr_mem #(
    .MEM_BYTES(4 * OBJECT_COUNT)
  ) u_mem (
    .clk  (clk),
    .rst  (rst),
    .req  (mem_req),
    .rdata(mem_rdata)
  );

  sls_ctrl #(
    .OBJECT_COUNT(OBJECT_COUNT),
    .MAX_PER_LINE(MAX_PER_LINE)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .tall        (tall_objects),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .byte_address(byte_address),
    .write_byte  (write_byte),
    .line_number (line_number),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_byte   (read_byte),
    .object_index(object_index),
    .object_found(object_found),
    .last        (last),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata)
  );

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && object_found |-> {1'b0, object_index} < 7'(OBJECT_COUNT))
    else $error("object index out of range");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !object_found |-> last)
    else $error("non-hit result not marked last");

  a_scan_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && object_found |-> read_byte == 8'd0)
    else $error("scan result carries a byte");

  a_write_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == MODE_WRITE |=> in_ready)
    else $error("write transaction held the input");

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sprite_line_search. Byte writes and reads to the object
// attribute memory and line scans run against an in-bench prediction of
// the memory and the visible object list. Both the 8 and 16 line object
// heights are used, with random sender bursts, output stalls and one long
// output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import sls_pkg::*;

  localparam int OAM_BYTES      = OBJECT_COUNT_DEF * 4;
  localparam int MAX_REPORTS    = 10;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 2 * OBJECT_COUNT_DEF + 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 140;
  localparam int PHASE_ITEMS    = 60;
  localparam int CYCLE_LIMIT    = 400000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [5:0] object_index;
    logic       object_found;
    logic       last;
  } line_result_t;

  class oam_scan_scoreboard;
    logic [7:0] attr_mem [OAM_BYTES];
    bit tall;
    line_result_t awaited [$];
    int errors, results, writes, reads, scans, capped, empty_scans;

    function new();
      foreach (attr_mem[i]) attr_mem[i] = 8'h00;
      tall = 1'b0;
    endfunction

    function void set_tall(bit v);
      tall = v;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void expect_result(line_result_t r);
      awaited.insert(awaited.size(), r);
    endfunction

    function void note_item(logic [1:0] m, logic [7:0] addr, logic [7:0] data,
                            logic [7:0] scan_line);
      line_result_t r;
      logic [7:0] y, lower, upper, height;
      int hits;
      hits = 0;
      r = '0;
      case (m)
        MODE_WRITE: begin
          writes++;
          if (addr < OAM_BYTES) attr_mem[addr] = data;
        end
        MODE_READ: begin
          reads++;
          r.read_byte = (addr < OAM_BYTES) ? attr_mem[addr] : READ_MISS;
          r.last = 1'b1;
          expect_result(r);
        end
        MODE_SCAN: begin
          scans++;
          height = tall ? HEIGHT_TALL : HEIGHT_SHORT;
          for (int i = 0; i < OBJECT_COUNT_DEF && hits < MAX_PER_LINE_DEF; i++) begin
            y = attr_mem[4 * i];
            if (y == 8'h00 || y >= Y_LIMIT) continue;
            // 8-bit wrap on both bounds
            lower = y - Y_OFFSET;
            upper = y - Y_OFFSET + height;
            if (scan_line >= lower && scan_line < upper) begin
              r = '0;
              r.object_index = 6'(i);
              r.object_found = 1'b1;
              expect_result(r);
              hits++;
            end
          end
          if (hits == 0) begin
            empty_scans++;
            r = '0;
            r.last = 1'b1;
            expect_result(r);
          end else begin
            awaited[awaited.size() - 1].last = 1'b1;
          end
          if (hits == MAX_PER_LINE_DEF) capped++;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [7:0] rb, logic [5:0] idx, logic found,
                               logic lst);
      line_result_t got, want;
      got = '{rb, idx, found, lst};
      results++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: read_byte=%02h index=%0d found=%b last=%b",
                   rb, idx, found, lst);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: expected read_byte=%02h index=%0d found=%b last=%b, %s%02h %s%0d %s%b %s%b",
                   want.read_byte, want.object_index, want.object_found, want.last,
                   "got read_byte=", rb, "index=", idx, "found=", found,
                   "last=", lst);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] mode = MODE_WRITE;
  logic [7:0] byte_address = 8'h00;
  logic [7:0] write_byte = 8'h00;
  logic [7:0] line_number = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_byte;
  logic [5:0] object_index;
  logic       object_found;
  logic       last;

  oam_scan_scoreboard sb = new();
  int cycle_count = 0;
  int items_sent = 0;
  int burst_left = 0;

  sprite_line_search uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .byte_address (byte_address),
    .write_byte   (write_byte),
    .line_number  (line_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_byte    (read_byte),
    .object_index (object_index),
    .object_found (object_found),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(read_byte, object_index, object_found, last);
  end

  // output side: changing stall patterns plus one long hold-off
  initial begin : receiver
    int pattern_sel, pattern_left, hold_left, tick;
    bit hold_done;
    pattern_sel = 0;
    pattern_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (pattern_left == 0) begin
        pattern_sel = $urandom_range(0, 3);
        pattern_left = $urandom_range(20, 80);
      end
      pattern_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (pattern_sel)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (tick % 3 == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_item(logic [1:0] m, logic [7:0] addr, logic [7:0] data,
                           logic [7:0] scan_line);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid     <= 1'b1;
    mode         <= m;
    byte_address <= addr;
    write_byte   <= data;
    line_number  <= scan_line;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    sb.note_item(m, addr, data, scan_line);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic set_height(bit tall_sel);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= tall_sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_tall(tall_sel);
  endtask

  // fill every Y byte close to focus, then scan a line that sees them all
  task automatic fill_and_scan(logic [7:0] focus);
    for (int i = 0; i < OBJECT_COUNT_DEF; i++)
      send_item(MODE_WRITE, 8'(4 * i), 8'(focus + $urandom_range(0, 7)), 8'($urandom));
    send_item(MODE_SCAN, 8'($urandom), 8'($urandom), focus - 8'd9);
  endtask

  task automatic random_items(int count, logic [7:0] focus);
    int done_items, dice;
    logic [7:0] addr, data, scan_line;
    done_items = 0;
    while (done_items < count) begin
      dice = $urandom_range(0, 99);
      addr = 8'($urandom_range(0, OAM_BYTES - 1));
      data = 8'($urandom);
      scan_line = 8'($urandom);
      if (dice < 35) begin
        addr = 8'(4 * $urandom_range(0, OBJECT_COUNT_DEF - 1));
        if ($urandom_range(0, 3) != 0) data = 8'(focus + $urandom_range(0, 15));
        send_item(MODE_WRITE, addr, data, scan_line);
        done_items++;
      end else if (dice < 50) begin
        send_item(MODE_WRITE, addr, data, scan_line);
        done_items++;
      end else if (dice < 68) begin
        if ($urandom_range(0, 7) == 0) addr = 8'($urandom);
        send_item(MODE_READ, addr, data, scan_line);
        done_items++;
      end else if (dice < 93) begin
        if ($urandom_range(0, 3) != 0)
          scan_line = 8'(focus - 8'd16 + $urandom_range(0, 23));
        send_item(MODE_SCAN, addr, data, scan_line);
        done_items++;
      end else if (dice < 97) begin
        send_item(MODE_UNUSED, addr, data, scan_line);
      end else begin
        send_item(MODE_WRITE, 8'($urandom_range(OAM_BYTES, 255)), data, scan_line);
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] focus;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_height(1'b0);

    // reset contents, reads past the end, ignored items
    send_item(MODE_READ, 8'd0, 8'hFF, 8'hFF);
    send_item(MODE_READ, 8'd159, 8'h00, 8'h00);
    send_item(MODE_READ, 8'd160, 8'hAA, 8'h55);
    send_item(MODE_READ, 8'd255, 8'h55, 8'hAA);
    send_item(MODE_WRITE, 8'd200, 8'h55, 8'd0);
    send_item(MODE_READ, 8'd200, 8'h00, 8'd0);
    send_item(MODE_UNUSED, 8'd0, 8'hFF, 8'hFF);
    send_item(MODE_SCAN, 8'd0, 8'h00, 8'd0);
    // Y bytes at the edges: top row, bottom, off limits, wrapped bounds
    send_item(MODE_WRITE, 8'd0, 8'd16, 8'd0);
    send_item(MODE_WRITE, 8'd4, 8'd159, 8'd0);
    send_item(MODE_WRITE, 8'd8, 8'd160, 8'd0);
    send_item(MODE_WRITE, 8'd12, 8'd255, 8'd0);
    send_item(MODE_WRITE, 8'd16, 8'd8, 8'd0);
    send_item(MODE_WRITE, 8'd159, 8'hFF, 8'd0);
    send_item(MODE_READ, 8'd159, 8'h00, 8'd0);
    send_item(MODE_SCAN, 8'hFF, 8'hFF, 8'd0);
    send_item(MODE_SCAN, 8'd0, 8'd0, 8'd7);
    send_item(MODE_SCAN, 8'd0, 8'd0, 8'd8);
    send_item(MODE_SCAN, 8'd0, 8'd0, 8'd143);
    send_item(MODE_SCAN, 8'd0, 8'd0, 8'd150);
    send_item(MODE_SCAN, 8'd0, 8'd0, 8'd151);
    send_item(MODE_SCAN, 8'd0, 8'd0, 8'd153);
    send_item(MODE_SCAN, 8'd0, 8'd0, 8'd248);
    send_item(MODE_SCAN, 8'd0, 8'd0, 8'd255);

    for (int p = 0; p < 3; p++) begin
      set_height(p != 1);
      focus = 8'($urandom_range(24, 150));
      fill_and_scan(focus);
      random_items(PHASE_ITEMS - OBJECT_COUNT_DEF - 1, focus);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d writes, %0d reads, %0d scans (%0d capped, %0d empty), %0d results",
             sb.writes, sb.reads, sb.scans, sb.capped, sb.empty_scans, sb.results);
    $display("object heights 8 and 16 both used, with one long output hold-off");
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire

// File: sprite_line_search.f
hw/rtl/sls_pkg.sv
hw/rtl/sls_attr_mem.sv
hw/rtl/sls_ctrl.sv
hw/rtl/sprite_line_search.sv
dv/tb_top.sv
